### rtl/core/wba_pkg.sv
// ---------------------------------------------------------------------------
// wba_pkg
// Shared widths, register indexes and timer helpers of the wiper blockage
// adapter.
// ---------------------------------------------------------------------------
package wba_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TMR_W      = 20;
    localparam int CYC_W      = 10;
    localparam int CNT_W      = 16;
    localparam int LOSS_W     = 8;
    localparam int PROB_W     = 8;

    // dividend is 10 * a 16-bit count: 20 bits, one quotient bit per cycle
    localparam int DIV_BITS   = 20;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_WIPER_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTOFF_WAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTOFF_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_LOSS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_DELAY  = 3'd6;

    localparam logic [1:0] TERM_WAY   = 2'd0;
    localparam logic [1:0] TERM_TIME  = 2'd1;
    localparam logic [1:0] TERM_RANGE = 2'd2;
    localparam logic [1:0] TERM_LOSS  = 2'd3;

    localparam logic [TMR_W-1:0]  TMR_MAX          = 20'hFFFFF;
    localparam logic [TMR_W-1:0]  PARTIAL_LIMIT_MS = 20'd600000;
    localparam logic [PROB_W-1:0] PROB_MAX         = 8'd255;

    // saturating timer advance
    function automatic logic [TMR_W-1:0] tmr_add(input logic [TMR_W-1:0] t,
                                                 input logic [CYC_W-1:0] d);
        logic [TMR_W:0] s;
        s = {1'b0, t} + {{(TMR_W+1-CYC_W){1'b0}}, d};
        return s[TMR_W] ? TMR_MAX : s[TMR_W-1:0];
    endfunction

    // 10 * x as (x << 3) + (x << 1)
    function automatic logic [DIV_BITS-1:0] times10(input logic [CNT_W-1:0] x);
        logic [DIV_BITS-1:0] w;
        w = {{(DIV_BITS-CNT_W){1'b0}}, x};
        return (w << 3) + (w << 1);
    endfunction

endpackage

### rtl/core/wiper_blockage_adapter_top.sv
// ---------------------------------------------------------------------------
// wiper_blockage_adapter_top
// Blockage probability from observer counters, plus wiper permit, extended
// hold-on and partial blockage timers.
// ---------------------------------------------------------------------------
// Input beats are not taken while a beat is in progress (in_stall outside ST_IDLE);
//   four ratios share one bit-serial restoring divider, a load then 20 quotient
//   bits each, then an update state that waits for a free result register.
// A new input beat is taken while the previous result still waits.
// Reset (rst_n, async, active low): registers except input payload 0, timers 0,
//   hold-on flag 1, extension timer not idle, no result pending.
// ---------------------------------------------------------------------------
module wiper_blockage_adapter_top (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [wba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wba_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          wiper_active,
    input  logic                          full_blockage,
    input  logic [wba_pkg::CYC_W-1:0]     cycle_time_ms,
    input  logic [wba_pkg::CNT_W-1:0]     way_counter,
    input  logic [wba_pkg::CNT_W-1:0]     time_counter,
    input  logic [wba_pkg::CNT_W-1:0]     range_counter,
    input  logic [wba_pkg::CNT_W-1:0]     recovery_counter,
    input  logic [wba_pkg::LOSS_W-1:0]    object_losses,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wba_pkg::PROB_W-1:0]    probability,
    output logic                          hold_off,
    output logic                          hold_on
);
    import wba_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_UPD
    } state_t;

    // configuration
    logic [17:0]       wiper_delay_reg;
    logic [TMR_W-1:0]  verify_time_reg;
    logic [CNT_W-1:0]  shutoff_way_reg;
    logic [CNT_W-1:0]  shutoff_time_reg;
    logic [CNT_W-1:0]  range_hold_reg;
    logic [LOSS_W-1:0] allowed_loss_reg;
    logic [CNT_W-1:0]  react_delay_reg;

    // latched input beat
    logic              wiper_reg;
    logic              full_reg;
    logic [CYC_W-1:0]  cyc_reg;
    logic [CNT_W-1:0]  way_reg;
    logic [CNT_W-1:0]  tim_reg;
    logic [CNT_W-1:0]  rng_reg;
    logic [CNT_W-1:0]  rec_reg;
    logic [LOSS_W-1:0] loss_reg;

    // sequencer and divider
    state_t                state_reg;
    logic [1:0]            term_reg;
    logic [DIV_CNT_W-1:0]  bit_cnt_reg;
    logic [DIV_BITS-1:0]   num_sr_reg;    // dividend in, quotient out
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      den_reg;
    logic                  en_reg;
    logic [PROB_W-1:0]     prob_reg;

    // block state
    logic              permit_reg;
    logic [TMR_W-1:0]  permit_timer_reg;
    logic              last_permit_reg;
    logic              extend_flag_reg;
    logic [TMR_W-1:0]  extend_timer_reg;
    logic              extend_idle_reg;
    logic              partial_flag_reg;
    logic [TMR_W-1:0]  partial_timer_reg;

    // result register
    logic              out_valid_reg;
    logic [PROB_W-1:0] probability_reg;
    logic              hold_off_reg;
    logic              hold_on_reg;

    // ------------------------------------------------------------------
    // Term setup: every ratio is floor(num / den) with num = 10 * count
    // (10 * (delay - range) on the recovery side). Clamped ratios divide
    // 10 * min(count, threshold), which yields 10 when the count reaches the threshold. en low forces the term to 0.
    // ------------------------------------------------------------------
    logic [DIV_BITS-1:0] ld_num;
    logic [CNT_W-1:0]    ld_den;
    logic                ld_en;

    always_comb
    begin
        ld_num = '0;
        ld_den = '0;
        ld_en  = 1'b0;
        case (term_reg)
            TERM_WAY:
            begin
                ld_num = times10((way_reg >= shutoff_way_reg) ? shutoff_way_reg : way_reg);
                ld_den = shutoff_way_reg;
                ld_en  = (shutoff_way_reg != '0);
            end
            TERM_TIME:
            begin
                ld_num = times10((tim_reg >= shutoff_time_reg) ? shutoff_time_reg : tim_reg);
                ld_den = shutoff_time_reg;
                ld_en  = (shutoff_time_reg != '0);
            end
            TERM_RANGE:
            begin
                if (full_reg)
                begin
                    // recovery side: 1 - range / delay, zero once range reaches delay
                    ld_num = times10(react_delay_reg - rng_reg);
                    ld_den = react_delay_reg;
                    ld_en  = (react_delay_reg != '0) && (rng_reg < react_delay_reg);
                end
                else
                begin
                    ld_num = times10((rng_reg >= range_hold_reg) ? range_hold_reg : rng_reg);
                    ld_den = range_hold_reg;
                    ld_en  = (range_hold_reg != '0);
                end
            end
            TERM_LOSS:
            begin
                // not clamped; saturates at 255 when folded
                if (full_reg)
                begin
                    ld_num = times10(rec_reg);
                    ld_den = react_delay_reg;
                    ld_en  = (allowed_loss_reg != '0) && (react_delay_reg != '0);
                end
                else
                begin
                    ld_num = times10({{(CNT_W-LOSS_W){1'b0}}, loss_reg});
                    ld_den = {{(CNT_W-LOSS_W){1'b0}}, allowed_loss_reg};
                    ld_en  = (allowed_loss_reg != '0);
                end
            end
            default:
            begin
                ld_num = '0;
                ld_den = '0;
                ld_en  = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [CNT_W:0]      div_shift;
    logic                div_qbit;
    logic [CNT_W-1:0]    div_rem_next;
    logic [DIV_BITS-1:0] div_num_next;
    logic [PROB_W-1:0]   term_sat;
    logic [PROB_W-1:0]   prob_fold;
    logic [CNT_W:0]      div_diff;

    always_comb
    begin
        div_shift    = {rem_reg, num_sr_reg[DIV_BITS-1]};
        div_qbit     = (div_shift >= {1'b0, den_reg});
        div_diff     = div_shift - {1'b0, den_reg};
        div_rem_next = div_qbit ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        div_num_next = {num_sr_reg[DIV_BITS-2:0], div_qbit};
        if (!en_reg)
            term_sat = '0;
        else if (div_num_next[DIV_BITS-1:PROB_W] != '0)
            term_sat = PROB_MAX;
        else
            term_sat = div_num_next[PROB_W-1:0];
        prob_fold = (term_sat > prob_reg) ? term_sat : prob_reg;
    end

    // ------------------------------------------------------------------
    // Timer update, applied in ST_UPD with the final probability
    // ------------------------------------------------------------------
    logic              permit_next;
    logic [TMR_W-1:0]  permit_timer_next;
    logic              extend_flag_next;
    logic [TMR_W-1:0]  extend_timer_next;
    logic              extend_idle_next;
    logic              partial_flag_next;
    logic [TMR_W-1:0]  partial_timer_next;
    logic [TMR_W-1:0]  ext_base;
    logic [TMR_W-1:0]  part_base;
    logic [TMR_W-1:0]  part_sum;
    logic              part_set;

    always_comb
    begin
        // permit
        permit_next       = permit_reg;
        permit_timer_next = permit_timer_reg;
        if (wiper_reg)
        begin
            if (!permit_reg)
            begin
                if (permit_timer_reg < {2'b00, wiper_delay_reg})
                    permit_timer_next = tmr_add(permit_timer_reg, cyc_reg);
                else
                    permit_next = 1'b1;
            end
        end
        else
        begin
            permit_timer_next = '0;
            permit_next       = 1'b0;
        end

        // extended hold-on
        ext_base          = extend_idle_reg ? '0 : extend_timer_reg;
        extend_flag_next  = extend_flag_reg;
        extend_timer_next = extend_timer_reg;
        extend_idle_next  = extend_idle_reg;
        if (!full_reg)
        begin
            extend_idle_next  = 1'b1;
            extend_timer_next = '0;
            extend_flag_next  = 1'b0;
        end
        else
        begin
            extend_idle_next = 1'b0;
            if (extend_idle_reg)
                extend_flag_next = 1'b1;
            if (ext_base < verify_time_reg)
                extend_timer_next = tmr_add(ext_base, cyc_reg);
            else
            begin
                extend_timer_next = ext_base;
                extend_flag_next  = 1'b0;
            end
        end

        // partial blockage: starts on a falling permit with nonzero probability
        part_set           = last_permit_reg && !permit_next && (prob_reg != '0);
        part_base          = part_set ? '0 : partial_timer_reg;
        part_sum           = tmr_add(part_base, cyc_reg);
        partial_flag_next  = partial_flag_reg || part_set;
        partial_timer_next = part_base;
        if (partial_flag_next)
        begin
            partial_timer_next = part_sum;
            if ((part_sum > PARTIAL_LIMIT_MS) || (prob_reg == '0))
            begin
                partial_flag_next  = 1'b0;
                partial_timer_next = '0;
            end
        end
    end

    logic in_take;
    logic out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiper_delay_reg  <= '0;
            verify_time_reg  <= '0;
            shutoff_way_reg  <= '0;
            shutoff_time_reg <= '0;
            range_hold_reg   <= '0;
            allowed_loss_reg <= '0;
            react_delay_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIPER_DELAY:  wiper_delay_reg  <= cfg_data[17:0];
                CFG_VERIFY_TIME:  verify_time_reg  <= cfg_data[TMR_W-1:0];
                CFG_SHUTOFF_WAY:  shutoff_way_reg  <= cfg_data[CNT_W-1:0];
                CFG_SHUTOFF_TIME: shutoff_time_reg <= cfg_data[CNT_W-1:0];
                CFG_RANGE_HOLD:   range_hold_reg   <= cfg_data[CNT_W-1:0];
                CFG_ALLOWED_LOSS: allowed_loss_reg <= cfg_data[LOSS_W-1:0];
                CFG_REACT_DELAY:  react_delay_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture, payload only
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            wiper_reg <= wiper_active;
            full_reg  <= full_blockage;
            cyc_reg   <= cycle_time_ms;
            way_reg   <= way_counter;
            tim_reg   <= time_counter;
            rng_reg   <= range_counter;
            rec_reg   <= recovery_counter;
            loss_reg  <= object_losses;
        end
    end

    // sequencer, block state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            term_reg          <= TERM_WAY;
            bit_cnt_reg       <= '0;
            num_sr_reg        <= '0;
            rem_reg           <= '0;
            den_reg           <= '0;
            en_reg            <= 1'b0;
            prob_reg          <= '0;
            permit_reg        <= 1'b0;
            permit_timer_reg  <= '0;
            last_permit_reg   <= 1'b0;
            extend_flag_reg   <= 1'b1;
            extend_timer_reg  <= '0;
            extend_idle_reg   <= 1'b0;
            partial_flag_reg  <= 1'b0;
            partial_timer_reg <= '0;
            out_valid_reg     <= 1'b0;
            probability_reg   <= '0;
            hold_off_reg      <= 1'b0;
            hold_on_reg       <= 1'b0;
        end
        else
        begin
            // the update cycle reloads the result register itself
            if (out_valid_reg && !out_stall && (state_reg != ST_UPD))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        term_reg  <= TERM_WAY;
                        prob_reg  <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    num_sr_reg  <= ld_num;
                    den_reg     <= ld_den;
                    en_reg      <= ld_en;
                    rem_reg     <= '0;
                    bit_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    num_sr_reg <= div_num_next;
                    rem_reg    <= div_rem_next;
                    if (bit_cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
                    begin
                        prob_reg <= prob_fold;
                        if (term_reg == TERM_LOSS)
                            state_reg <= ST_UPD;
                        else
                        begin
                            term_reg  <= term_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                    else
                        bit_cnt_reg <= bit_cnt_reg + DIV_CNT_W'(1);
                end
                ST_UPD:
                begin
                    // commit only once the result register is free
                    if (out_free)
                    begin
                        permit_reg        <= permit_next;
                        permit_timer_reg  <= permit_timer_next;
                        last_permit_reg   <= permit_next;
                        extend_flag_reg   <= extend_flag_next;
                        extend_timer_reg  <= extend_timer_next;
                        extend_idle_reg   <= extend_idle_next;
                        partial_flag_reg  <= partial_flag_next;
                        partial_timer_reg <= partial_timer_next;
                        out_valid_reg     <= 1'b1;
                        probability_reg   <= prob_reg;
                        hold_off_reg      <= !permit_next && !partial_flag_next && !full_reg;
                        hold_on_reg       <= extend_flag_next;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign probability = probability_reg;
    assign hold_off    = hold_off_reg;
    assign hold_on     = hold_on_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside the update cycle");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (bit_cnt_reg < DIV_CNT_W'(DIV_BITS)))
        else $error("divider bit count out of range");

    a_partial_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        partial_timer_reg <= PARTIAL_LIMIT_MS)
        else $error("partial blockage timer above limit");

    a_take_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_LOAD) && (term_reg == TERM_WAY))
        else $error("input beat did not start the ratio sequence");

    a_idle_clears_partial_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !partial_flag_reg |-> (partial_timer_reg == '0))
        else $error("partial timer running while partial blockage is off");

endmodule
